// ===== hw/rtl/pem_pkg.sv =====
package pem_pkg;

    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int PIX_W       = 8;
    localparam int POS_W       = 12;
    localparam int LAG_W       = 13;
    localparam int GRAD_W      = 11;
    localparam int SQ_W        = 20;
    localparam int SUM_W       = 21;
    localparam int RAD_W       = 16;
    localparam int ROOT_W      = 8;
    localparam int STEP_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [STEP_W-1:0] TAP_COUNT  = 4'd9;
    localparam logic [STEP_W-1:0] ROOT_FIRST = 4'd7;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] gray_pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             end_of_frame;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic              accept_pixel;
        logic              acc_clear;
        logic              tap_issue;
        logic [STEP_W-1:0] tap_idx;
        logic              acc_en;
        logic              square_en;
        logic              sum_en;
        logic              root_en;
        logic [2:0]        root_bit;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pix_emit;
        logic flush_emit;
        logic out_free;
    } dp_status_t;

    // Row offset of a window tap: -1 for the upper row, +1 for the lower row.
    function automatic logic signed [1:0] tap_dr(input logic [STEP_W-1:0] t);
        logic signed [1:0] d;
        unique case (t)
            4'd0, 4'd1, 4'd2: d = -2'sd1;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // Column offset of a window tap: -1 for the left column, +1 for the right column.
    function automatic logic signed [1:0] tap_dc(input logic [STEP_W-1:0] t);
        logic signed [1:0] d;
        unique case (t)
            4'd0, 4'd3, 4'd6: d = -2'sd1;
            4'd2, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/prewitt_edge_magnitude.sv =====
// Prewitt edge magnitude over a 3x3 window with replicated borders.
// Input channel (in_valid/in_ready/in_data) takes gray pixels in raster order;
// each flush item drains one of the results still pending once the whole frame is in.
// Output channel (out_valid/out_ready/out_data) gives floor(sqrt(gx^2 + gy^2))
// saturated at 255, with end_of_frame set on the frame's last result.
// Results trail the input by one row plus one pixel.
// An item that causes no result leaves the block ready for the next item. An
// item that causes a result goes through window reads through the single read
// port of the pixel ring memory, a square step, a sum step, the bit-serial
// square root and a load of the output register.
// The result sits in an output register, so the next item is accepted while it
// waits; a stalled receiver holds the next result in the final state.
// Configuration writes (cfg_we/cfg_index/cfg_data) restart the frame.
// Reset restores 640x480 and clears all positions; the ring memory is not
// cleared because it is read only at pixels written in the current frame.
module prewitt_edge_magnitude
    import pem_pkg::*;
#(
    parameter int LINE_PIXELS_MAX = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (in_data.func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pem_datapath #(
        .LINE_PIXELS_MAX (LINE_PIXELS_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .gray_pixel (in_data.gray_pixel),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== hw/rtl/pem_ctrl.sv =====
module pem_ctrl
    import pem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       func,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.tap_idx  = step_reg;
        cmd.root_bit = step_reg[2:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.acc_clear    = 1'b1;
                    cmd.accept_pixel = (func == FUNC_PIXEL);
                    if ((func == FUNC_PIXEL) ? status.pix_emit : status.flush_emit)
                    begin
                        state_next = ST_READ;
                        step_next  = '0;
                    end
                end
            end
            ST_READ:
            begin
                cmd.tap_issue = (step_reg < TAP_COUNT);
                cmd.acc_en    = (step_reg != '0);
                step_next     = step_reg + 1'b1;
                if (step_reg == TAP_COUNT)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square_en = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                step_next  = ROOT_FIRST;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_en = 1'b1;
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pem_datapath.sv =====
module pem_datapath
    import pem_pkg::*;
#(
    parameter int LINE_PIXELS_MAX = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [PIX_W-1:0]     gray_pixel,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);

    localparam int RING_AW    = $clog2(2 * LINE_PIXELS_MAX + 3);
    localparam int RING_DEPTH = 1 << RING_AW;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [POS_W-1:0]   w_eff;
    logic [POS_W-1:0]   h_eff;
    logic [RING_AW-1:0] w_aw;

    logic [POS_W-1:0]   in_col_reg, in_col_next;
    logic [POS_W-1:0]   in_row_reg, in_row_next;
    logic [RING_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [POS_W-1:0]   out_col_reg, out_col_next;
    logic [POS_W-1:0]   out_row_reg, out_row_next;
    logic [RING_AW-1:0] out_ptr_reg, out_ptr_next;
    logic [LAG_W-1:0]   lag_reg, lag_next;

    logic               in_done;
    logic               out_last;
    logic [POS_W-1:0]   base_col, base_row;
    logic [RING_AW-1:0] base_ptr;
    logic [LAG_W-1:0]   base_lag;

    logic [PIX_W-1:0]   ring_mem [RING_DEPTH];
    logic [RING_AW-1:0] rd_addr;
    logic [RING_AW-1:0] row_term, col_term;
    logic [PIX_W-1:0]   rd_data_reg;
    logic [STEP_W-1:0]  rd_tap_reg;

    logic signed [1:0]        issue_dr, issue_dc;
    logic signed [1:0]        acc_dr, acc_dc;
    logic signed [GRAD_W-1:0] pix_ext;
    logic signed [GRAD_W-1:0] gx_reg, gx_next;
    logic signed [GRAD_W-1:0] gy_reg, gy_next;
    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [SQ_W-1:0]          sq_x_reg, sq_y_reg;
    logic [SUM_W-1:0]         sum;
    logic [RAD_W-1:0]         rad_reg;
    logic                     sat_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [ROOT_W-1:0]        trial;
    logic [RAD_W-1:0]         trial_sq;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        priority if (width_reg == '0)
        begin
            w_eff = POS_W'(1);
        end
        else if (32'(width_reg) > LINE_PIXELS_MAX)
        begin
            w_eff = POS_W'(LINE_PIXELS_MAX);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? POS_W'(1) : height_reg;
    end

    assign w_aw     = RING_AW'(w_eff);
    assign in_done  = (in_row_reg >= h_eff);
    assign out_last = (out_row_reg == h_eff - 1'b1) && (out_col_reg == w_eff - 1'b1);

    // A pixel that arrives after a complete frame starts the next frame with itself.
    assign base_col = in_done ? '0 : in_col_reg;
    assign base_row = in_done ? '0 : in_row_reg;
    assign base_ptr = in_done ? '0 : wr_ptr_reg;
    assign base_lag = in_done ? '0 : lag_reg;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        wr_ptr_next  = wr_ptr_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_ptr_next = out_ptr_reg;
        lag_next     = lag_reg;
        priority if (cfg_we || (cmd.out_load && out_last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            wr_ptr_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            out_ptr_next = '0;
            lag_next     = '0;
        end
        else if (cmd.accept_pixel)
        begin
            wr_ptr_next = base_ptr + 1'b1;
            lag_next    = base_lag + 1'b1;
            if (in_done)
            begin
                out_col_next = '0;
                out_row_next = '0;
                out_ptr_next = '0;
            end
            if (base_col + 1'b1 >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = base_row + 1'b1;
            end
            else
            begin
                in_col_next = base_col + 1'b1;
                in_row_next = base_row;
            end
        end
        else if (cmd.out_load)
        begin
            out_ptr_next = out_ptr_reg + 1'b1;
            lag_next     = lag_reg - 1'b1;
            if (out_col_reg + 1'b1 >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            wr_ptr_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_ptr_reg <= '0;
            lag_reg     <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            wr_ptr_reg  <= wr_ptr_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_ptr_reg <= out_ptr_next;
            lag_reg     <= lag_next;
        end
    end

    assign status.pix_emit   = !in_done && (lag_reg >= LAG_W'(w_eff) + 1'b1);
    assign status.flush_emit = in_done && (lag_reg != '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Neighbors outside the frame fold back onto the nearest row or column.
    assign issue_dr = tap_dr(cmd.tap_idx);
    assign issue_dc = tap_dc(cmd.tap_idx);

    always_comb
    begin
        row_term = '0;
        col_term = '0;
        if ((issue_dr < 0) && (out_row_reg != '0))
        begin
            row_term = RING_AW'(0) - w_aw;
        end
        else if ((issue_dr > 0) && (out_row_reg != h_eff - 1'b1))
        begin
            row_term = w_aw;
        end
        if ((issue_dc < 0) && (out_col_reg != '0))
        begin
            col_term = RING_AW'(0) - RING_AW'(1);
        end
        else if ((issue_dc > 0) && (out_col_reg != w_eff - 1'b1))
        begin
            col_term = RING_AW'(1);
        end
        rd_addr = out_ptr_reg + row_term + col_term;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_pixel)
        begin
            ring_mem[base_ptr] <= gray_pixel;
        end
        rd_data_reg <= ring_mem[rd_addr];
        if (cmd.tap_issue)
        begin
            rd_tap_reg <= cmd.tap_idx;
        end
    end

    assign acc_dr  = tap_dr(rd_tap_reg);
    assign acc_dc  = tap_dc(rd_tap_reg);
    assign pix_ext = $signed({{(GRAD_W-PIX_W){1'b0}}, rd_data_reg});

    always_comb
    begin
        gx_next = gx_reg;
        gy_next = gy_reg;
        if (acc_dc > 0)
        begin
            gx_next = gx_reg + pix_ext;
        end
        else if (acc_dc < 0)
        begin
            gx_next = gx_reg - pix_ext;
        end
        if (acc_dr > 0)
        begin
            gy_next = gy_reg + pix_ext;
        end
        else if (acc_dr < 0)
        begin
            gy_next = gy_reg - pix_ext;
        end
    end

    assign prod_x   = gx_reg * gx_reg;
    assign prod_y   = gy_reg * gy_reg;
    assign sum      = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign trial    = root_reg | (ROOT_W'(1) << cmd.root_bit);
    assign trial_sq = RAD_W'(trial) * RAD_W'(trial);

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
        begin
            gx_reg <= '0;
            gy_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (cmd.square_en)
        begin
            sq_x_reg <= prod_x[SQ_W-1:0];
            sq_y_reg <= prod_y[SQ_W-1:0];
        end
        if (cmd.sum_en)
        begin
            rad_reg  <= sum[RAD_W-1:0];
            sat_reg  <= (sum[SUM_W-1:RAD_W] != '0);
            root_reg <= '0;
        end
        else if (cmd.root_en && (trial_sq <= rad_reg))
        begin
            root_reg <= trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.edge_value   <= sat_reg ? {PIX_W{1'b1}} : root_reg;
            out_data_reg.end_of_frame <= out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
